@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/nec_ir_pkg.sv @@
package nec_ir_pkg;

   localparam int SEG_W    = 7;
   localparam int TICKS_W  = 16;
   localparam int PHASE_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADDRESS_BYTE   = 3'd0,
      CSR_CARRIER_PERIOD = 3'd1,
      CSR_CARRIER_LOW    = 3'd2,
      CSR_LEADER_MARK    = 3'd3,
      CSR_LEADER_SPACE   = 3'd4,
      CSR_BIT_MARK       = 3'd5,
      CSR_ONE_SPACE      = 3'd6,
      CSR_END_GAP        = 3'd7
   } csr_index_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] command;
   } req_payload_type;

   typedef struct packed {
      logic ir_level;
      logic busy_res;
      logic frame_done;
      logic start_ignored;
   } rsp_payload_type;

   // register reset values
   localparam logic [7:0]         ADDRESS_RST       = 8'h80;
   localparam logic [7:0]         CARRIER_PERIOD_RST = 8'd26;
   localparam logic [7:0]         CARRIER_LOW_RST   = 8'd5;
   localparam logic [TICKS_W-1:0] LEADER_MARK_RST   = 16'd9000;
   localparam logic [TICKS_W-1:0] LEADER_SPACE_RST  = 16'd4500;
   localparam logic [TICKS_W-1:0] BIT_MARK_RST      = 16'd560;
   localparam logic [TICKS_W-1:0] ONE_SPACE_RST     = 16'd1680;
   localparam logic [TICKS_W-1:0] END_GAP_RST       = 16'd40000;

endpackage

@@ rtl/core/nec_ir_frame_transmitter_core.sv @@
// nec infrared frame transmitter, advanced one timer tick per tick transfer
//
// req channel: each transfer is either a tick (time moves on by one tick) or
// a start that loads the command byte; a start is taken only when idle, a
// start while a frame runs is flagged start_ignored and changes nothing.
// rsp channel: exactly one result per req transfer, in order: the pin level
// for that tick, busy, the end-of-frame strobe and the ignored-start flag.
// csr channel: register writes (index, data), always ready, one per cycle; the user
// writes only while no frame is running and no result is pending; not enforced here.
//
// result: registered, and valid in the cycle after its req transfer.
// throughput: one req transfer per cycle unless rsp stalls, set by the single result
// register; all per-tick work is one pass of compare and increment logic.
// stall: req_ready follows rsp_ready while a result waits, so a stalled rsp
// side holds the req side without losing or repeating anything.
// reset: registers take their default timing values (38 kHz carrier at a
// 1 MHz tick, standard nec lengths), the block is idle, no result pending.
`include "assert_macros.svh"

module nec_ir_frame_transmitter_core #(
   parameter int FRAME_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  nec_ir_pkg::req_payload_type             req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output nec_ir_pkg::rsp_payload_type             rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  nec_ir_pkg::csr_index_type               csr_index,
   input  logic [nec_ir_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import nec_ir_pkg::*;

   // segment map: 0 leader mark, 1 leader space, then mark/space per bit,
   // then trailer mark and end gap
   localparam logic [SEG_W-1:0] DATA_LAST_SEG = SEG_W'(2 + 2 * FRAME_BITS);
   localparam logic [SEG_W-1:0] LAST_SEG      = SEG_W'(3 + 2 * FRAME_BITS);

   // configuration registers
   logic [7:0]         address_ff;
   logic [7:0]         period_ff;
   logic [7:0]         low_ff;
   logic [TICKS_W-1:0] leader_mark_ff;
   logic [TICKS_W-1:0] leader_space_ff;
   logic [TICKS_W-1:0] bit_mark_ff;
   logic [TICKS_W-1:0] one_space_ff;
   logic [TICKS_W-1:0] end_gap_ff;

   // frame state
   logic                  active_ff, active_in;
   logic [SEG_W-1:0]      seg_ff, seg_in;
   logic [TICKS_W-1:0]    ticks_ff, ticks_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic               req_xfer;
   logic               seg_mark;
   logic [SEG_W-1:0]   bit_idx;
   logic [FRAME_BITS-1:0] frame_shifted;
   logic               frame_bit;
   logic [TICKS_W-1:0] seg_len;
   logic               seg_end;
   logic               phase_wrap;
   logic [31:0]        frame_word;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff      <= ADDRESS_RST;
         period_ff       <= CARRIER_PERIOD_RST;
         low_ff          <= CARRIER_LOW_RST;
         leader_mark_ff  <= LEADER_MARK_RST;
         leader_space_ff <= LEADER_SPACE_RST;
         bit_mark_ff     <= BIT_MARK_RST;
         one_space_ff    <= ONE_SPACE_RST;
         end_gap_ff      <= END_GAP_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ADDRESS_BYTE:   address_ff      <= csr_wdata[7:0];
            CSR_CARRIER_PERIOD: period_ff       <= csr_wdata[7:0];
            CSR_CARRIER_LOW:    low_ff          <= csr_wdata[7:0];
            CSR_LEADER_MARK:    leader_mark_ff  <= csr_wdata;
            CSR_LEADER_SPACE:   leader_space_ff <= csr_wdata;
            CSR_BIT_MARK:       bit_mark_ff     <= csr_wdata;
            CSR_ONE_SPACE:      one_space_ff    <= csr_wdata;
            CSR_END_GAP:        end_gap_ff      <= csr_wdata;
         endcase
      end
   end

   // marks are the leader mark, every bit mark and the trailer mark
   assign seg_mark = (seg_ff <= DATA_LAST_SEG) && !seg_ff[0];

   // data space 2k+3 carries frame bit k
   assign bit_idx       = (seg_ff >> 1) - SEG_W'(1);
   assign frame_shifted = frame_ff >> bit_idx;
   assign frame_bit     = frame_shifted[0];

   always_comb begin
      priority if (seg_ff == '0) begin
         seg_len = leader_mark_ff;
      end else if (seg_ff == SEG_W'(1)) begin
         seg_len = leader_space_ff;
      end else if (seg_ff <= DATA_LAST_SEG) begin
         seg_len = (!seg_ff[0] || !frame_bit) ? bit_mark_ff : one_space_ff;
      end else begin
         seg_len = end_gap_ff;
      end
   end

   // a zero length still takes one tick
   assign seg_end    = ({1'b0, ticks_ff} + (TICKS_W+1)'(1)) >= {1'b0, seg_len};
   assign phase_wrap = ({1'b0, phase_ff} + (PHASE_W+1)'(1)) >= {1'b0, period_ff};

   // address, inverted address, command, inverted command, lsb first
   assign frame_word = {~req_data.command, req_data.command, ~address_ff, address_ff};

   always_comb begin
      active_in = active_ff;
      seg_in    = seg_ff;
      ticks_in  = ticks_ff;
      phase_in  = phase_ff;
      frame_in  = frame_ff;
      rsp_in.ir_level      = 1'b1;
      rsp_in.frame_done    = 1'b0;
      rsp_in.start_ignored = 1'b0;
      if (req_data.op == OP_START) begin
         if (active_ff) begin
            rsp_in.start_ignored = 1'b1;
         end else begin
            frame_in  = frame_word[FRAME_BITS-1:0];
            active_in = 1'b1;
            seg_in    = '0;
            ticks_in  = '0;
            phase_in  = '0;
         end
      end else if (active_ff) begin
         if (seg_mark) begin
            // active-low carrier
            rsp_in.ir_level = !(phase_ff < low_ff);
            phase_in = phase_wrap ? '0 : phase_ff + PHASE_W'(1);
         end
         if (seg_end) begin
            ticks_in = '0;
            phase_in = '0;
            if (seg_ff >= LAST_SEG) begin
               active_in = 1'b0;
               seg_in    = '0;
               rsp_in.frame_done = 1'b1;
            end else begin
               seg_in = seg_ff + SEG_W'(1);
            end
         end else begin
            ticks_in = ticks_ff + TICKS_W'(1);
         end
      end
      rsp_in.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         seg_ff       <= '0;
         ticks_ff     <= '0;
         phase_ff     <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            active_ff <= active_in;
            seg_ff    <= seg_in;
            ticks_ff  <= ticks_in;
            phase_ff  <= phase_in;
            frame_ff  <= frame_in;
         end
         if (req_ready) begin
            rsp_valid_ff <= req_valid;
         end
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_ff.frame_done, !rsp_ff.busy_res)
   `ASSERT_IMPLY(a_ignored_busy, clock, reset, rsp_valid_ff && rsp_ff.start_ignored, rsp_ff.busy_res)
   `ASSERT_ALWAYS(a_seg_range, clock, reset, seg_ff <= LAST_SEG)
   `ASSERT_IMPLY(a_idle_seg_zero, clock, reset, !active_ff, seg_ff == '0 && ticks_ff == '0)
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_ff))

endmodule
